FILE: src/biased_matrix_factorization_sgd_top_assert.svh
// ----------------------------------------------------------------------------
// biased matrix factorization sgd assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef BIASED_MATRIX_FACTORIZATION_SGD_TOP_ASSERT_SVH
`define BIASED_MATRIX_FACTORIZATION_SGD_TOP_ASSERT_SVH

// same-cycle implication
`define BMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmf check failed");

// next-cycle implication
`define BMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmf check failed");

`endif

FILE: src/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// types, constants and fixed-point helpers of the matrix factorization block
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

    localparam int USER_W     = 12;
    localparam int ITEM_W     = 12;
    localparam int FAC_W      = 7;
    localparam int FACTORS    = 128;
    localparam int BIAS_DEPTH = 4096;
    localparam int FMEM_DEPTH = 524288;
    localparam int CNT_W      = 12;
    localparam int WORD_W     = 32;
    localparam int MEAN_W     = 19;
    localparam int RATE_W     = 16;
    localparam int RATING_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 19;
    localparam int ACC_W      = 56;
    localparam int WIDE_W     = 70;
    localparam int RND_W      = 54;

    localparam logic signed [WORD_W-1:0] CLIP_LO = 32'sh0001_0000;
    localparam logic signed [WORD_W-1:0] CLIP_HI = 32'sh0005_0000;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_TRAIN   = 2'd1,
        ACT_PREDICT = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        TGT_UBIAS   = 2'd0,
        TGT_IBIAS   = 2'd1,
        TGT_UFACTOR = 2'd2,
        TGT_IFACTOR = 2'd3
    } target_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEAN    = 3'd0,
        CFG_UB_RATE = 3'd1,
        CFG_IB_RATE = 3'd2,
        CFG_UF_RATE = 3'd3,
        CFG_IF_RATE = 3'd4,
        CFG_B_DECAY = 3'd5,
        CFG_F_DECAY = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic              clear;
        logic [CNT_W-1:0]  addr;
        logic              latch;
        logic              load;
        logic              bias_rd;
        logic              acc_clr;
        logic              dot_rd;
        logic              upd_rd;
        logic [FAC_W-1:0]  k;
        logic              bias_go;
        logic              pred;
        logic              err;
        logic              zero;
        logic              out_ld;
    } cmd_t;

    typedef struct packed {
        action_t action;
    } status_t;

    // drop 16 fraction bits, nearest, ties toward plus infinity
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] t;
        begin
            t = (x + WIDE_W'(32768)) >>> 16;
            rnd16 = t[RND_W-1:0];
        end
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        begin
            if (x > WIDE_W'(64'sh0000_0000_7FFF_FFFF))
                sat32 = 32'sh7FFF_FFFF;
            else if (x < -WIDE_W'(64'sh0000_0000_8000_0000))
                sat32 = 32'sh8000_0000;
            else
                sat32 = x[WORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/biased_matrix_factorization_sgd_top.sv
// ----------------------------------------------------------------------------
// biased_matrix_factorization_sgd_top
// biased matrix factorization with sgd training, q16.16 saturating math
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  cfg      cfg_write            cfg_index, cfg_data
//  in       in_valid / in_stall  action, user_index, item_index, rating,
//                                load_target, factor_index, load_value
//  out      out_valid / out_stall prediction, error
//
//  train: two passes over 128 factor words
//  after reset a sweep over all 4096 addresses zeroes both bias memories, in_stall held high
//  a finished beat waits in the output register; the next beat is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module biased_matrix_factorization_sgd_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bmf_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           action,
    input  wire logic [bmf_pkg::USER_W-1:0]           user_index,
    input  wire logic [bmf_pkg::ITEM_W-1:0]           item_index,
    input  wire logic [bmf_pkg::RATING_W-1:0]         rating,
    input  wire logic [1:0]                           load_target,
    input  wire logic [bmf_pkg::FAC_W-1:0]            factor_index,
    input  wire logic signed [bmf_pkg::WORD_W-1:0]    load_value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [bmf_pkg::WORD_W-1:0]         prediction,
    output logic signed [bmf_pkg::WORD_W-1:0]         error
);

    bmf_pkg::cmd_t    cmd;
    bmf_pkg::status_t status;

    bmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bmf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .user_index   (user_index),
        .item_index   (item_index),
        .rating       (rating),
        .load_target  (load_target),
        .factor_index (factor_index),
        .load_value   (load_value),
        .cmd          (cmd),
        .status       (status),
        .prediction   (prediction),
        .error        (error)
    );

endmodule

`default_nettype wire

FILE: src/bmf_datapath.sv
// ----------------------------------------------------------------------------
// bmf_datapath
// bias and factor memories, dot product accumulator and sgd update pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bmf_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic [1:0]                           action,
    input  wire logic [bmf_pkg::USER_W-1:0]           user_index,
    input  wire logic [bmf_pkg::ITEM_W-1:0]           item_index,
    input  wire logic [bmf_pkg::RATING_W-1:0]         rating,
    input  wire logic [1:0]                           load_target,
    input  wire logic [bmf_pkg::FAC_W-1:0]            factor_index,
    input  wire logic signed [bmf_pkg::WORD_W-1:0]    load_value,
    input  wire bmf_pkg::cmd_t                        cmd,
    output bmf_pkg::status_t                          status,
    output logic signed [bmf_pkg::WORD_W-1:0]         prediction,
    output logic signed [bmf_pkg::WORD_W-1:0]         error
);

    localparam int W  = bmf_pkg::WORD_W;
    localparam int XW = bmf_pkg::WIDE_W;
    localparam int RW = bmf_pkg::RATE_W;
    localparam int FA = bmf_pkg::USER_W + bmf_pkg::FAC_W;

    // configuration
    logic [bmf_pkg::MEAN_W-1:0] mean_reg;
    logic [RW-1:0] ubr_reg, ibr_reg, ufr_reg, ifr_reg, bdec_reg, fdec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= 19'd229376;
            ubr_reg  <= 16'd328;
            ibr_reg  <= 16'd328;
            ufr_reg  <= 16'd655;
            ifr_reg  <= 16'd655;
            bdec_reg <= 16'd3277;
            fdec_reg <= 16'd6554;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bmf_pkg::CFG_MEAN:    mean_reg <= cfg_data;
                bmf_pkg::CFG_UB_RATE: ubr_reg  <= cfg_data[RW-1:0];
                bmf_pkg::CFG_IB_RATE: ibr_reg  <= cfg_data[RW-1:0];
                bmf_pkg::CFG_UF_RATE: ufr_reg  <= cfg_data[RW-1:0];
                bmf_pkg::CFG_IF_RATE: ifr_reg  <= cfg_data[RW-1:0];
                bmf_pkg::CFG_B_DECAY: bdec_reg <= cfg_data[RW-1:0];
                bmf_pkg::CFG_F_DECAY: fdec_reg <= cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // beat capture
    bmf_pkg::action_t                 act_reg;
    logic [bmf_pkg::USER_W-1:0]       u_reg;
    logic [bmf_pkg::ITEM_W-1:0]       i_reg;
    logic [bmf_pkg::RATING_W-1:0]     rating_reg;
    bmf_pkg::target_t                 tgt_reg;
    logic [bmf_pkg::FAC_W-1:0]        f_reg;
    logic signed [W-1:0]              val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg    <= bmf_pkg::action_t'(action);
            u_reg      <= user_index;
            i_reg      <= item_index;
            rating_reg <= rating;
            tgt_reg    <= bmf_pkg::target_t'(load_target);
            f_reg      <= factor_index;
            val_reg    <= load_value;
        end
    end

    assign status.action = act_reg;

    // pipeline valids
    logic d1_reg, d2_reg, u1_reg, u2_reg, u3_reg, u4_reg, b1_reg, b2_reg, b3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= 1'b0;
            d2_reg <= 1'b0;
            u1_reg <= 1'b0;
            u2_reg <= 1'b0;
            u3_reg <= 1'b0;
            u4_reg <= 1'b0;
            b1_reg <= 1'b0;
            b2_reg <= 1'b0;
            b3_reg <= 1'b0;
        end
        else
        begin
            d1_reg <= cmd.dot_rd;
            d2_reg <= d1_reg;
            u1_reg <= cmd.upd_rd;
            u2_reg <= u1_reg;
            u3_reg <= u2_reg;
            u4_reg <= u3_reg;
            b1_reg <= cmd.bias_go;
            b2_reg <= b1_reg;
            b3_reg <= b2_reg;
        end
    end

    // bias memories
    logic [W-1:0] ub_mem [bmf_pkg::BIAS_DEPTH];
    logic [W-1:0] ib_mem [bmf_pkg::BIAS_DEPTH];
    logic signed [W-1:0] bu_q, bi_q;
    logic signed [W-1:0] bnew_u, bnew_i;
    logic ub_we, ib_we;
    logic [bmf_pkg::USER_W-1:0] ub_wa;
    logic [bmf_pkg::ITEM_W-1:0] ib_wa;
    logic [W-1:0] ub_wd, ib_wd;

    always_comb
    begin
        ub_we = cmd.clear || (cmd.load && tgt_reg == bmf_pkg::TGT_UBIAS) || b3_reg;
        ib_we = cmd.clear || (cmd.load && tgt_reg == bmf_pkg::TGT_IBIAS) || b3_reg;
        ub_wa = cmd.clear ? cmd.addr[bmf_pkg::USER_W-1:0] : u_reg;
        ib_wa = cmd.clear ? cmd.addr[bmf_pkg::ITEM_W-1:0] : i_reg;
        ub_wd = cmd.clear ? '0 : (cmd.load ? val_reg : bnew_u);
        ib_wd = cmd.clear ? '0 : (cmd.load ? val_reg : bnew_i);
    end

    always_ff @(posedge clk)
    begin
        if (ub_we)
            ub_mem[ub_wa] <= ub_wd;
        if (cmd.bias_rd)
            bu_q <= ub_mem[u_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ib_we)
            ib_mem[ib_wa] <= ib_wd;
        if (cmd.bias_rd)
            bi_q <= ib_mem[i_reg];
    end

    // factor memories
    logic [W-1:0] uf_mem [bmf_pkg::FMEM_DEPTH];
    logic [W-1:0] if_mem [bmf_pkg::FMEM_DEPTH];
    logic signed [W-1:0] p_q, q_q;
    logic signed [W-1:0] pnew, qnew;
    logic [bmf_pkg::FAC_W-1:0] k1_reg, k2_reg, k3_reg, k4_reg;
    logic uf_we, if_we;
    logic [FA-1:0] uf_wa, if_wa;
    logic [W-1:0] uf_wd, if_wd;
    logic f_rd;

    always_comb
    begin
        f_rd  = cmd.dot_rd || cmd.upd_rd;
        uf_we = (cmd.load && tgt_reg == bmf_pkg::TGT_UFACTOR) || u4_reg;
        if_we = (cmd.load && tgt_reg == bmf_pkg::TGT_IFACTOR) || u4_reg;
        uf_wa = cmd.load ? {u_reg, f_reg} : {u_reg, k4_reg};
        if_wa = cmd.load ? {i_reg, f_reg} : {i_reg, k4_reg};
        uf_wd = cmd.load ? val_reg : pnew;
        if_wd = cmd.load ? val_reg : qnew;
    end

    always_ff @(posedge clk)
    begin
        if (uf_we)
            uf_mem[uf_wa] <= uf_wd;
        if (f_rd)
            p_q <= uf_mem[{u_reg, cmd.k}];
    end

    always_ff @(posedge clk)
    begin
        if (if_we)
            if_mem[if_wa] <= if_wd;
        if (f_rd)
            q_q <= if_mem[{i_reg, cmd.k}];
    end

    // dot product
    logic signed [2*W-1:0] prod_reg;
    logic signed [bmf_pkg::ACC_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (d1_reg)
            prod_reg <= p_q * q_q;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (d2_reg)
            acc_reg <= acc_reg + bmf_pkg::ACC_W'(bmf_pkg::rnd16(XW'(prod_reg)));
    end

    // prediction and error
    logic signed [W-1:0] pred_reg, err_reg;
    logic signed [XW-1:0] sum;
    logic signed [W-1:0] sum_sat;

    always_comb
    begin
        sum = XW'($signed({1'b0, mean_reg})) + XW'(bu_q) + XW'(bi_q) + XW'(acc_reg);
        sum_sat = bmf_pkg::sat32(sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.zero)
        begin
            pred_reg <= '0;
            err_reg  <= '0;
        end
        else if (cmd.pred)
        begin
            err_reg <= '0;
            if (act_reg == bmf_pkg::ACT_PREDICT)
            begin
                if (sum_sat < bmf_pkg::CLIP_LO)
                    pred_reg <= bmf_pkg::CLIP_LO;
                else if (sum_sat > bmf_pkg::CLIP_HI)
                    pred_reg <= bmf_pkg::CLIP_HI;
                else
                    pred_reg <= sum_sat;
            end
            else
                pred_reg <= sum_sat;
        end
        else if (cmd.err)
            err_reg <= bmf_pkg::sat32(XW'($signed({1'b0, rating_reg, 16'h0000})) - XW'(pred_reg));
    end

    // bias update
    logic signed [48:0] bmu_reg, bmi_reg;
    logic signed [bmf_pkg::RND_W-1:0] gu_reg, gi_reg;
    logic signed [XW-1:0] ru_reg, ri_reg;

    always_ff @(posedge clk)
    begin
        if (b1_reg || cmd.bias_go)
        begin
            bmu_reg <= $signed({1'b0, bdec_reg}) * bu_q;
            bmi_reg <= $signed({1'b0, bdec_reg}) * bi_q;
        end
        if (b1_reg)
        begin
            gu_reg <= bmf_pkg::rnd16(XW'($signed({err_reg, 16'h0000})) - XW'(bmu_reg));
            gi_reg <= bmf_pkg::rnd16(XW'($signed({err_reg, 16'h0000})) - XW'(bmi_reg));
        end
        if (b2_reg)
        begin
            ru_reg <= XW'($signed({1'b0, ubr_reg}) * gu_reg);
            ri_reg <= XW'($signed({1'b0, ibr_reg}) * gi_reg);
        end
    end

    always_comb
    begin
        bnew_u = bmf_pkg::sat32(XW'(bu_q) + XW'(bmf_pkg::rnd16(ru_reg)));
        bnew_i = bmf_pkg::sat32(XW'(bi_q) + XW'(bmf_pkg::rnd16(ri_reg)));
    end

    // factor update
    logic signed [2*W-1:0] eq_reg, ep_reg;
    logic signed [48:0] dp_reg, dq_reg;
    logic signed [W-1:0] p2_reg, q2_reg, p3_reg, q3_reg, p4_reg, q4_reg;
    logic signed [bmf_pkg::RND_W-1:0] gp_reg, gq_reg;
    logic signed [XW-1:0] rp_reg, rq_reg;

    always_ff @(posedge clk)
    begin
        k1_reg <= cmd.k;
        if (u1_reg)
        begin
            eq_reg <= err_reg * q_q;
            ep_reg <= err_reg * p_q;
            dp_reg <= $signed({1'b0, fdec_reg}) * p_q;
            dq_reg <= $signed({1'b0, fdec_reg}) * q_q;
            p2_reg <= p_q;
            q2_reg <= q_q;
            k2_reg <= k1_reg;
        end
        if (u2_reg)
        begin
            gp_reg <= bmf_pkg::rnd16(XW'(eq_reg) - XW'(dp_reg));
            gq_reg <= bmf_pkg::rnd16(XW'(ep_reg) - XW'(dq_reg));
            p3_reg <= p2_reg;
            q3_reg <= q2_reg;
            k3_reg <= k2_reg;
        end
        if (u3_reg)
        begin
            rp_reg <= XW'($signed({1'b0, ufr_reg}) * gp_reg);
            rq_reg <= XW'($signed({1'b0, ifr_reg}) * gq_reg);
            p4_reg <= p3_reg;
            q4_reg <= q3_reg;
            k4_reg <= k3_reg;
        end
    end

    always_comb
    begin
        pnew = bmf_pkg::sat32(XW'(p4_reg) + XW'(bmf_pkg::rnd16(rp_reg)));
        qnew = bmf_pkg::sat32(XW'(q4_reg) + XW'(bmf_pkg::rnd16(rq_reg)));
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            prediction <= pred_reg;
            error      <= err_reg;
        end
    end

endmodule

`default_nettype wire

FILE: src/bmf_ctrl.sv
// ----------------------------------------------------------------------------
// bmf_ctrl
// sequencer for clearing, load, dot product, bias and factor update phases
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire bmf_pkg::status_t  status,
    output bmf_pkg::cmd_t          cmd
);

    `include "biased_matrix_factorization_sgd_top_assert.svh"

    localparam int CW = bmf_pkg::CNT_W;

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0_0000_0000_0001,
        S_IDLE   = 13'b0_0000_0000_0010,
        S_DECODE = 13'b0_0000_0000_0100,
        S_LOAD   = 13'b0_0000_0000_1000,
        S_BREAD  = 13'b0_0000_0001_0000,
        S_DOT    = 13'b0_0000_0010_0000,
        S_DDRAIN = 13'b0_0000_0100_0000,
        S_PRED   = 13'b0_0000_1000_0000,
        S_ERR    = 13'b0_0001_0000_0000,
        S_BIAS   = 13'b0_0010_0000_0000,
        S_UPD    = 13'b0_0100_0000_0000,
        S_UDRAIN = 13'b0_1000_0000_0000,
        S_RESULT = 13'b1_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.addr   = cnt_reg;
        cmd.k      = cnt_reg[bmf_pkg::FAC_W-1:0];
        in_stall   = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(bmf_pkg::BIAS_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.latch = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cnt_next = '0;
                unique case (status.action) inside
                    bmf_pkg::ACT_LOAD:    state_next = S_LOAD;
                    bmf_pkg::ACT_TRAIN,
                    bmf_pkg::ACT_PREDICT: state_next = S_BREAD;
                    default:
                    begin
                        cmd.zero   = 1'b1;
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                cmd.zero   = 1'b1;
                state_next = S_RESULT;
            end
            S_BREAD:
            begin
                cmd.bias_rd = 1'b1;
                cmd.acc_clr = 1'b1;
                cnt_next    = '0;
                state_next  = S_DOT;
            end
            S_DOT:
            begin
                cmd.dot_rd = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CW'(bmf_pkg::FACTORS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DDRAIN;
                end
            end
            S_DDRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(1))
                    state_next = S_PRED;
            end
            S_PRED:
            begin
                cmd.pred   = 1'b1;
                cnt_next   = '0;
                state_next = (status.action == bmf_pkg::ACT_TRAIN) ? S_ERR : S_RESULT;
            end
            S_ERR:
            begin
                cmd.err    = 1'b1;
                state_next = S_BIAS;
            end
            S_BIAS:
            begin
                cmd.bias_go = (cnt_reg == '0);
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CW'(3))
                begin
                    cnt_next   = '0;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd_rd = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CW'(bmf_pkg::FACTORS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_UDRAIN;
                end
            end
            S_UDRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(3))
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_ld)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    `BMF_ASSERT_IMP(a_no_overwrite, cmd.out_ld && out_valid_reg, !out_stall)
    `BMF_ASSERT_NXT(a_accept_decode, in_valid && !in_stall, state_reg == S_DECODE)
    `BMF_ASSERT_IMP(a_phase_excl, cmd.dot_rd, !cmd.upd_rd && !cmd.clear)

endmodule

`default_nettype wire
